// ===== rtl/core/srdt_pkg.sv =====
// Package for the scan result dedup table: request codes, sizes and the
// command record passed from the front end to the table engine. No dependencies.
package srdt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int NAME_WORDS = 4;
  localparam int NAME_BYTES = 32;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
    logic [5:0]  len;
    logic [7:0]  sig;
    logic [7:0]  chan;
    logic [7:0]  sec;
    logic [5:0]  idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WRITE,
    ST_READ_RD,
    ST_DONE
  } eng_state_t;

  function automatic logic [63:0] word_mask(input logic [5:0] len, input int k);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = ({2'b00, len} > 8'(k*8 + b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/srdt_front.sv =====
// Front end: accepts requests, turns bad reports into no-ops, masks name bytes,
// then queues commands for the engine. Depends on srdt_pkg.
module srdt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  srdt_pkg::cmd_t       in_cmd,
  output logic                 cmd_valid,
  output srdt_pkg::cmd_t       cmd_out,
  input  logic                 cmd_take
);
  srdt_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  srdt_pkg::cmd_t cls;
  logic       do_push, do_pop;

  // Drop the stray name bytes; turn bad-length reports into no-ops.
  always_comb begin
    cls = in_cmd;
    cls.w0 = in_cmd.w0 & srdt_pkg::word_mask(in_cmd.len, 0);
    cls.w1 = in_cmd.w1 & srdt_pkg::word_mask(in_cmd.len, 1);
    cls.w2 = in_cmd.w2 & srdt_pkg::word_mask(in_cmd.len, 2);
    cls.w3 = in_cmd.w3 & srdt_pkg::word_mask(in_cmd.len, 3);
    if (in_cmd.req == srdt_pkg::REQ_REPORT &&
        (in_cmd.len == 6'd0 || in_cmd.len > 6'(srdt_pkg::NAME_BYTES))) begin
      cls.req = srdt_pkg::REQ_NONE;
    end
  end

  assign full = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_out = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("command queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && push) |=> cnt_r == 2'd1)
    else $error("push into empty queue lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !cmd_take) |=> cnt_r == 2'd2)
    else $error("full queue changed without pop");
endmodule

// ===== rtl/core/srdt_engine.sv =====
// Table engine: walks stored entries in turn to match, update, append
// or read, and holds one result for the output side. Depends on srdt_pkg.
module srdt_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  srdt_pkg::cmd_t       cmd,
  output logic                 cmd_take,
  output logic                 res_empty,
  input  logic                 res_pop,
  output logic [63:0]          r_w0,
  output logic [63:0]          r_w1,
  output logic [63:0]          r_w2,
  output logic [63:0]          r_w3,
  output logic [5:0]           r_len,
  output logic signed [7:0]    r_sig,
  output logic [7:0]           r_chan,
  output logic [7:0]           r_sec,
  output logic                 r_valid,
  output logic [5:0]           r_count,
  output logic                 r_ovf
);
  localparam int AW = srdt_pkg::IDX_W;
  localparam int CW = srdt_pkg::CNT_W;

  // Entry memory, one row holds the whole record.
  logic [255:0] name_mem [srdt_pkg::ENTRIES];
  logic [5:0]   len_mem  [srdt_pkg::ENTRIES];
  logic [7:0]   sig_mem  [srdt_pkg::ENTRIES];
  logic [7:0]   chan_mem [srdt_pkg::ENTRIES];
  logic [7:0]   sec_mem  [srdt_pkg::ENTRIES];

  logic [255:0] rd_name_r;
  logic [5:0]   rd_len_r;
  logic [7:0]   rd_sig_r, rd_chan_r, rd_sec_r;

  srdt_pkg::eng_state_t st_r, st_nxt;
  srdt_pkg::cmd_t cur_r;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] fill_r;
  logic          ovf_r;
  logic          have_r;
  logic          hit_r;

  logic          rd_en, wr_en, upd_en, match, stronger;
  logic [AW-1:0] rd_addr;
  logic [255:0]  cur_name;

  assign cur_name = {cur_r.w3, cur_r.w2, cur_r.w1, cur_r.w0};
  assign match = (rd_len_r == cur_r.len) && (rd_name_r == cur_name);
  assign stronger = $signed(cur_r.sig) > $signed(rd_sig_r);
  assign res_empty = !have_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    ptr_nxt = ptr_r;
    unique case (st_r)
      srdt_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          ptr_nxt = '0;
          unique case (cmd.req)
            srdt_pkg::REQ_REPORT: st_nxt = srdt_pkg::ST_SCAN_RD;
            srdt_pkg::REQ_READ:   st_nxt = srdt_pkg::ST_READ_RD;
            srdt_pkg::REQ_CLEAR,
            srdt_pkg::REQ_NONE:   st_nxt = srdt_pkg::ST_DONE;
          endcase
        end
      end
      srdt_pkg::ST_SCAN_RD:
        st_nxt = (ptr_r < fill_r) ? srdt_pkg::ST_SCAN_CMP : srdt_pkg::ST_WRITE;
      srdt_pkg::ST_SCAN_CMP: begin
        if (match) st_nxt = srdt_pkg::ST_DONE;
        else begin
          st_nxt = srdt_pkg::ST_SCAN_RD;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      srdt_pkg::ST_WRITE:   st_nxt = srdt_pkg::ST_DONE;
      srdt_pkg::ST_READ_RD: st_nxt = srdt_pkg::ST_DONE;
      srdt_pkg::ST_DONE:    if (!have_r) st_nxt = srdt_pkg::ST_IDLE;
      default:              st_nxt = srdt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    cmd_take = 1'b0;
    rd_en = 1'b0;
    rd_addr = ptr_r[AW-1:0];
    wr_en = 1'b0;
    upd_en = 1'b0;
    unique case (st_r)
      srdt_pkg::ST_IDLE: cmd_take = cmd_valid;
      srdt_pkg::ST_SCAN_RD: rd_en = (ptr_r < fill_r);
      srdt_pkg::ST_SCAN_CMP: upd_en = match && stronger;
      srdt_pkg::ST_WRITE: wr_en = (fill_r < CW'(srdt_pkg::ENTRIES));
      srdt_pkg::ST_READ_RD: begin
        rd_en = ({1'b0, cur_r.idx} < 7'(fill_r));
        rd_addr = cur_r.idx[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_name_r <= name_mem[rd_addr];
      rd_len_r  <= len_mem[rd_addr];
      rd_sig_r  <= sig_mem[rd_addr];
      rd_chan_r <= chan_mem[rd_addr];
      rd_sec_r  <= sec_mem[rd_addr];
    end
    if (wr_en) begin
      name_mem[fill_r[AW-1:0]] <= cur_name;
      len_mem[fill_r[AW-1:0]]  <= cur_r.len;
      sig_mem[fill_r[AW-1:0]]  <= cur_r.sig;
      chan_mem[fill_r[AW-1:0]] <= cur_r.chan;
      sec_mem[fill_r[AW-1:0]]  <= cur_r.sec;
    end
    if (upd_en) begin
      sig_mem[ptr_r[AW-1:0]]  <= cur_r.sig;
      chan_mem[ptr_r[AW-1:0]] <= cur_r.chan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur_r <= cmd;
    // Note whether a read hit a stored entry; other requests carry no entry.
    if (cmd_take) hit_r <= 1'b0;
    else if (st_r == srdt_pkg::ST_READ_RD) hit_r <= rd_en;
    // Load the result only once the previous one has been popped.
    if (st_r == srdt_pkg::ST_DONE && !have_r) begin
      r_valid <= hit_r;
      if (hit_r) begin
        {r_w3, r_w2, r_w1, r_w0} <= rd_name_r;
        r_len <= rd_len_r;
        r_sig <= rd_sig_r;
        r_chan <= rd_chan_r;
        r_sec <= rd_sec_r;
      end else begin
        {r_w3, r_w2, r_w1, r_w0} <= '0;
        r_len <= '0; r_sig <= '0; r_chan <= '0; r_sec <= '0;
      end
    end
    if (!rst_n) begin
      st_r <= srdt_pkg::ST_IDLE;
      ptr_r <= '0;
      fill_r <= '0;
      ovf_r <= 1'b0;
      have_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ptr_r <= ptr_nxt;
      if (st_r == srdt_pkg::ST_IDLE && cmd_take && cmd.req == srdt_pkg::REQ_CLEAR) begin
        fill_r <= '0;
        ovf_r <= 1'b0;
      end
      if (wr_en) fill_r <= fill_r + 1'b1;
      if (st_r == srdt_pkg::ST_WRITE && !wr_en) ovf_r <= 1'b1;
      if (res_pop && have_r) have_r <= 1'b0;
      if (st_r == srdt_pkg::ST_DONE && !have_r) begin
        have_r <= 1'b1;
        r_count <= 6'(fill_r);
        r_ovf <= ovf_r;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CW'(srdt_pkg::ENTRIES))
    else $error("fill count past table size");
  assert property (@(posedge clk) disable iff (!rst_n) wr_en |=> fill_r == $past(fill_r) + 1'b1)
    else $error("append did not advance fill count");
  assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && upd_en))
    else $error("append and update together");
endmodule

// ===== rtl/core/scan_result_dedup_table.sv =====
// Scan result dedup table, top level: front end queue plus table engine.
// Depends on srdt_pkg, srdt_front and srdt_engine.
// A clear or no-op goes straight to its result and a read fetches the indexed
// entry. A report compares stored entries in turn and stops at a match, which
// it updates if stronger, else appends or, with the table full, sets overflow.
// One transaction runs at a time; the next waits until this result is loaded.
// Reset (rst_n low, synchronous) empties the table and clears overflow.
module scan_result_dedup_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_req_type,
  input  logic [63:0]        in_name_word0,
  input  logic [63:0]        in_name_word1,
  input  logic [63:0]        in_name_word2,
  input  logic [63:0]        in_name_word3,
  input  logic [5:0]         in_name_len,
  input  logic signed [7:0]  in_signal_dbm,
  input  logic [7:0]         in_chan_num,
  input  logic [7:0]         in_security_mode,
  input  logic [5:0]         in_read_index,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        out_word0,
  output logic [63:0]        out_word1,
  output logic [63:0]        out_word2,
  output logic [63:0]        out_word3,
  output logic [5:0]         out_len,
  output logic signed [7:0]  out_signal,
  output logic [7:0]         out_chan,
  output logic [7:0]         out_security,
  output logic               out_entry_valid,
  output logic [5:0]         out_entry_count,
  output logic               out_overflow_flag
);
  srdt_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;

  // Pack the transaction into one command record.
  always_comb begin
    in_cmd.req  = srdt_pkg::req_t'(in_req_type);
    in_cmd.w0   = in_name_word0;
    in_cmd.w1   = in_name_word1;
    in_cmd.w2   = in_name_word2;
    in_cmd.w3   = in_name_word3;
    in_cmd.len  = in_name_len;
    in_cmd.sig  = in_signal_dbm;
    in_cmd.chan = in_chan_num;
    in_cmd.sec  = in_security_mode;
    in_cmd.idx  = in_read_index;
  end

  srdt_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_cmd(in_cmd),
    .cmd_valid(q_valid), .cmd_out(q_cmd), .cmd_take(q_take)
  );

  srdt_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd(q_cmd), .cmd_take(q_take),
    .res_empty(empty), .res_pop(pop),
    .r_w0(out_word0), .r_w1(out_word1), .r_w2(out_word2), .r_w3(out_word3),
    .r_len(out_len), .r_sig(out_signal), .r_chan(out_chan), .r_sec(out_security),
    .r_valid(out_entry_valid), .r_count(out_entry_count), .r_ovf(out_overflow_flag)
  );
endmodule
